FILE: design/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation block.
package qvr_pkg;

    // Field widths.
    localparam int QW   = 18;  // quaternion component, Q2.15
    localparam int PW   = 32;  // point coordinate, Q16.15
    localparam int CW   = 32;  // rotation matrix coefficient, Q1.30
    localparam int FRAC = 30;  // coefficient fraction bits
    localparam int MW   = 39;  // unnormalized matrix entry
    localparam int NW   = 37;  // squared norm
    localparam int SW   = 64;  // product and row sum

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_QUAT_I    = 2'd0;
    localparam logic [1:0] REG_QUAT_J    = 2'd1;
    localparam logic [1:0] REG_QUAT_K    = 2'd2;
    localparam logic [1:0] REG_QUAT_REAL = 2'd3;

    // Coefficient value of 1.0.
    localparam logic signed [CW-1:0] COEF_ONE = CW'(64'sd1 <<< FRAC);

    typedef logic signed [CW-1:0] t_coef;

    // Status and matrix from the coefficient unit to the datapath.
    typedef struct packed {
        logic           busy;
        logic           zero_q;
        t_coef [8:0]    m;
    } t_coef_bus;

endpackage

FILE: design/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotation block.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: point_x, point_y, point_z (32 bits each)
//  m_axis    out        tdata: rotated_x, rotated_y, rotated_z; tuser: zero_quaternion
//  cfg       in         write enable, index 0..3 (i, j, k, real), 18-bit data
//
//  A point reaches the output register through the four capture, multiply, sum and
//  saturate stages; one point is taken per cycle while the sequencer is idle and no
//  output stall holds it back. After reset, and after every register write, the
//  coefficient sequencer runs a product state and a sum state, then nine divisions of
//  one load state and restoring steps each (a zero norm loads the identity instead);
//  s_axis_tready is low meanwhile. Output stalls back up stage by stage without loss.
module quaternion_vector_rotate (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [qvr_pkg::QW-1:0]     i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [3*qvr_pkg::PW-1:0]   s_axis_tdata,  // point_x, point_y, point_z
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [3*qvr_pkg::PW-1:0]   m_axis_tdata,  // rotated_x, rotated_y, rotated_z
    output logic                       m_axis_tuser   // zero_quaternion
);

    qvr_pkg::t_coef_bus w_coef;

    // Quaternion registers and normalized matrix.
    qvr_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_coef     (w_coef)
    );

    // Point pipeline.
    qvr_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (w_coef),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_point  (s_axis_tdata),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (m_axis_tdata),
        .o_zero_q (m_axis_tuser)
    );

endmodule

FILE: design/qvr_coef.sv
// Quaternion registers and the sequencer that turns them into a normalized rotation matrix.
module qvr_coef (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_addr,
    input  logic [qvr_pkg::QW-1:0]  i_cfg_data,
    output qvr_pkg::t_coef_bus      o_coef
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PROD = 5'b00010,
        S_SUM  = 5'b00100,
        S_LOAD = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

    localparam int PRW = 2 * qvr_pkg::QW;

    t_state                        r_state;
    logic signed [qvr_pkg::QW-1:0] r_qi, r_qj, r_qk, r_qr;
    logic signed [PRW-1:0]         r_ii, r_jj, r_kk, r_rr, r_ij, r_ik, r_jk, r_ri, r_rj, r_rk;
    logic signed [qvr_pkg::MW-1:0] r_m [9];
    logic [qvr_pkg::NW-1:0]        r_n;
    logic [3:0]                    r_e;
    logic [4:0]                    r_cnt;
    logic [qvr_pkg::NW-1:0]        r_rem;
    logic [qvr_pkg::CW-1:0]        r_quot;
    logic                          r_neg;
    logic                          r_zero_q;
    qvr_pkg::t_coef                r_c [9];

    logic signed [qvr_pkg::MW-1:0] w_m;
    logic [qvr_pkg::MW-2:0]        w_abs;
    logic                          w_q0;
    logic [qvr_pkg::NW:0]          w_sh;
    logic                          w_ge;
    logic [qvr_pkg::NW-1:0]        n_rem;
    logic [qvr_pkg::CW-1:0]        n_quot;
    logic [qvr_pkg::CW:0]          w_round;
    qvr_pkg::t_coef                w_coef;

    // Selected entry and its magnitude for the first quotient bit.
    always_comb begin
        w_m   = r_m[r_e];
        w_abs = w_m[qvr_pkg::MW-1] ? (qvr_pkg::MW-1)'(-w_m) : w_m[qvr_pkg::MW-2:0];
        w_q0  = w_abs >= (qvr_pkg::MW-1)'(r_n);
    end

    // One restoring division step and the final rounding.
    always_comb begin
        w_sh    = {r_rem, 1'b0};
        w_ge    = w_sh >= {1'b0, r_n};
        n_rem   = w_ge ? qvr_pkg::NW'(w_sh - {1'b0, r_n}) : w_sh[qvr_pkg::NW-1:0];
        n_quot  = {r_quot[qvr_pkg::CW-2:0], w_ge};
        w_round = ({1'b0, n_quot} + (qvr_pkg::CW+1)'(1)) >> 1;
        w_coef  = r_neg ? -qvr_pkg::CW'(w_round) : qvr_pkg::CW'(w_round);
    end

    // Registers and sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_PROD;
            r_qi     <= '0;
            r_qj     <= '0;
            r_qk     <= '0;
            r_qr     <= qvr_pkg::QW'(32768);
            r_zero_q <= 1'b0;
            r_e      <= '0;
            r_cnt    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                qvr_pkg::REG_QUAT_I:    r_qi <= i_cfg_data;
                qvr_pkg::REG_QUAT_J:    r_qj <= i_cfg_data;
                qvr_pkg::REG_QUAT_K:    r_qk <= i_cfg_data;
                qvr_pkg::REG_QUAT_REAL: r_qr <= i_cfg_data;
                default: ;
            endcase
            r_state <= S_PROD;
        end else begin
            case (r_state)
                S_PROD: begin
                    r_ii    <= r_qi * r_qi;
                    r_jj    <= r_qj * r_qj;
                    r_kk    <= r_qk * r_qk;
                    r_rr    <= r_qr * r_qr;
                    r_ij    <= r_qi * r_qj;
                    r_ik    <= r_qi * r_qk;
                    r_jk    <= r_qj * r_qk;
                    r_ri    <= r_qr * r_qi;
                    r_rj    <= r_qr * r_qj;
                    r_rk    <= r_qr * r_qk;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_n    <= qvr_pkg::NW'(r_ii) + qvr_pkg::NW'(r_jj)
                            + qvr_pkg::NW'(r_kk) + qvr_pkg::NW'(r_rr);
                    r_m[0] <= qvr_pkg::MW'(r_rr) + qvr_pkg::MW'(r_ii)
                            - qvr_pkg::MW'(r_jj) - qvr_pkg::MW'(r_kk);
                    r_m[1] <= (qvr_pkg::MW'(r_ij) - qvr_pkg::MW'(r_rk)) <<< 1;
                    r_m[2] <= (qvr_pkg::MW'(r_ik) + qvr_pkg::MW'(r_rj)) <<< 1;
                    r_m[3] <= (qvr_pkg::MW'(r_ij) + qvr_pkg::MW'(r_rk)) <<< 1;
                    r_m[4] <= qvr_pkg::MW'(r_rr) - qvr_pkg::MW'(r_ii)
                            + qvr_pkg::MW'(r_jj) - qvr_pkg::MW'(r_kk);
                    r_m[5] <= (qvr_pkg::MW'(r_jk) - qvr_pkg::MW'(r_ri)) <<< 1;
                    r_m[6] <= (qvr_pkg::MW'(r_ik) - qvr_pkg::MW'(r_rj)) <<< 1;
                    r_m[7] <= (qvr_pkg::MW'(r_jk) + qvr_pkg::MW'(r_ri)) <<< 1;
                    r_m[8] <= qvr_pkg::MW'(r_rr) - qvr_pkg::MW'(r_ii)
                            - qvr_pkg::MW'(r_jj) + qvr_pkg::MW'(r_kk);
                    r_e     <= '0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_n == '0) begin
                        // Zero quaternion: identity matrix passes the point through.
                        for (int e = 0; e < 9; e++) begin
                            r_c[e] <= (e % 4 == 0) ? qvr_pkg::COEF_ONE : '0;
                        end
                        r_zero_q <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_zero_q <= 1'b0;
                        r_neg    <= w_m[qvr_pkg::MW-1];
                        r_quot   <= qvr_pkg::CW'(w_q0);
                        r_rem    <= w_q0 ? qvr_pkg::NW'(w_abs - (qvr_pkg::MW-1)'(r_n))
                                         : qvr_pkg::NW'(w_abs);
                        r_cnt    <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quot <= n_quot;
                    if (r_cnt == 5'(qvr_pkg::FRAC)) begin
                        r_c[r_e] <= w_coef;
                        if (r_e == 4'd8) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_e     <= r_e + 4'd1;
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Status and matrix out.
    always_comb begin
        o_coef.busy   = (r_state != S_IDLE);
        o_coef.zero_q = r_zero_q;
        for (int e = 0; e < 9; e++) begin
            o_coef.m[e] = r_c[e];
        end
    end

endmodule

FILE: design/qvr_datapath.sv
// Four-stage pipelined matrix-times-point datapath with rounding and saturation.
module qvr_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  qvr_pkg::t_coef_bus         i_coef,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [3*qvr_pkg::PW-1:0]   i_point,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [3*qvr_pkg::PW-1:0]   o_result,
    output logic                       o_zero_q
);

    localparam logic signed [qvr_pkg::SW-1:0] HALF = qvr_pkg::SW'(64'sd1 <<< (qvr_pkg::FRAC - 1));
    localparam int TW = qvr_pkg::SW - qvr_pkg::FRAC;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic signed [qvr_pkg::PW-1:0] r_p [3];
    logic signed [qvr_pkg::SW-1:0] r_prod [9];
    logic signed [qvr_pkg::SW-1:0] r_s [3];
    logic [qvr_pkg::PW-1:0]        r_out [3];
    logic signed [TW-1:0]          w_t [3];
    logic [qvr_pkg::PW-1:0]        w_sat [3];

    // Each stage moves when its successor is empty or moving.
    always_comb begin
        w_rdy4  = !r_v4 || i_ready;
        w_rdy3  = !r_v3 || w_rdy4;
        w_rdy2  = !r_v2 || w_rdy3;
        w_rdy1  = !r_v1 || w_rdy2;
        o_ready = w_rdy1 && !i_coef.busy;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid && !i_coef.busy;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Rounding shift and saturation of each row sum.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_t[r] = TW'(r_s[r] >>> qvr_pkg::FRAC);
            if (w_t[r] > TW'(64'sh7FFFFFFF)) begin
                w_sat[r] = 32'h7FFF_FFFF;
            end else if (w_t[r] < -TW'(64'sh80000000)) begin
                w_sat[r] = 32'h8000_0000;
            end else begin
                w_sat[r] = w_t[r][qvr_pkg::PW-1:0];
            end
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            for (int c = 0; c < 3; c++) begin
                r_p[c] <= i_point[c*qvr_pkg::PW +: qvr_pkg::PW];
            end
        end
        if (w_rdy2) begin
            for (int e = 0; e < 9; e++) begin
                r_prod[e] <= qvr_pkg::SW'($signed(i_coef.m[e])) * qvr_pkg::SW'(r_p[e % 3]);
            end
        end
        if (w_rdy3) begin
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= r_prod[3*r] + r_prod[3*r+1] + r_prod[3*r+2] + HALF;
            end
        end
        if (w_rdy4) begin
            for (int r = 0; r < 3; r++) begin
                r_out[r] <= w_sat[r];
            end
        end
    end

    assign o_valid  = r_v4;
    assign o_result = {r_out[2], r_out[1], r_out[0]};
    assign o_zero_q = i_coef.zero_q;

endmodule

FILE: design/qvr_checker.sv
// Port-level checker for the quaternion vector rotation block, with its bind.
module qvr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_we,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [3*qvr_pkg::PW-1:0]   m_axis_tdata
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // The matrix is rebuilt after reset, so no point is taken right away.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken before coefficients are ready");

    // A register write starts a rebuild that blocks input.
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input taken during coefficient rebuild");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
